### sv/ttd_pkg.sv
package ttd_pkg;

  // request codes
  localparam logic [1:0] REQ_ATTACH = 2'd0;
  localparam logic [1:0] REQ_TICK   = 2'd1;
  localparam logic [1:0] REQ_TOGGLE = 2'd2;

  // task kinds
  localparam logic [1:0] KIND_ALWAYS   = 2'd0;
  localparam logic [1:0] KIND_PERIODIC = 2'd1;
  localparam logic [1:0] KIND_ONESHOT  = 2'd2;

  // result codes
  localparam logic [2:0] RES_ATTACHED = 3'd0;
  localparam logic [2:0] RES_FULL     = 3'd1;
  localparam logic [2:0] RES_DISPATCH = 3'd2;
  localparam logic [2:0] RES_QUIET    = 3'd3;
  localparam logic [2:0] RES_TOGGLED  = 3'd4;
  localparam logic [2:0] RES_NOSUCH   = 3'd5;

  // dispatches reported per tick
  localparam logic [3:0] MAX_REPORT = 4'd8;

  typedef struct packed {
    logic [7:0]  handle;
    logic [1:0]  kind;
    logic        active;
    logic [7:0]  priority_lvl;
    logic [15:0] interval;
    logic [15:0] counter;
  } slot_t;

endpackage

### sv/tick_task_dispatcher_core.sv
// attach compares occupied entries from the last one down, then writes the new entry;
// tick visits each occupied slot; an unknown request gives no result
// throughput: one transaction at a time, each entry visited once a cycle through the
// single read/modify/write port pair of the slot memory; a stalled result adds its wait
// reset: sequencer, task count and output valid cleared; slot memory keeps its
// contents, entries are only read once an attach has written them
module tick_task_dispatcher_core #(
  parameter int SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [7:0]  in_task_handle,
  input  logic [1:0]  in_task_kind,
  input  logic        in_start_active,
  input  logic [7:0]  in_task_priority,
  input  logic [15:0] in_tick_interval,
  input  logic [2:0]  in_toggle_id,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_result_kind,
  output logic [2:0]  out_slot_id,
  output logic [7:0]  out_dispatched_handle,
  output logic        out_last_result
);
  import ttd_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int XW = (CW > 3) ? CW : 3;

  // sequencer states
  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_ATT_CHK = 3'd1;
  localparam logic [2:0] S_ATT_WR  = 3'd2;
  localparam logic [2:0] S_TK_CHK  = 3'd3;
  localparam logic [2:0] S_TK_END  = 3'd4;
  localparam logic [2:0] S_TG_CHK  = 3'd5;
  localparam logic [2:0] S_REPLY   = 3'd6;

  // slot table, one entry per task id, kept in priority order
  slot_t   mem [SLOTS];
  slot_t   rd_q;
  logic          mem_we, mem_re;
  logic [IW-1:0] mem_wa, mem_ra;
  slot_t         mem_wd;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q <= mem[mem_ra];
    end
  end

  // control state
  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [IW-1:0] pos_r, pos_nxt;
  logic          held_v_r, held_v_nxt;
  logic [3:0]    nd_r, nd_nxt;

  // latched request and pending results
  slot_t         rq_r, rq_nxt;
  logic [2:0]    rep_kind_r, rep_kind_nxt;
  logic [2:0]    rep_id_r, rep_id_nxt;
  logic [2:0]    held_id_r, held_id_nxt;
  logic [7:0]    held_handle_r, held_handle_nxt;

  // output register
  logic          out_valid_r;
  logic [2:0]    out_kind_r, out_id_r;
  logic [7:0]    out_handle_r;
  logic          out_last_r;

  logic          push;
  logic [2:0]    push_kind, push_id;
  logic [7:0]    push_handle;
  logic          push_last;
  logic          out_free;

  // tick helpers
  slot_t         upd;
  logic [16:0]   cnt_inc;
  logic          disp, rep_ok, stall;
  logic [CW-1:0] next_idx;
  logic [IW-1:0] tg_idx;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE);
  assign tg_idx   = IW'(in_toggle_id);
  assign next_idx = CW'(idx_r) + CW'(1);

  // per-slot update of a tick pass
  always_comb begin
    upd     = rd_q;
    cnt_inc = {1'b0, rd_q.counter} + 17'd1;
    unique case (rd_q.kind)
      KIND_ONESHOT: begin
        upd.active  = 1'b0;
        upd.counter = '0;
      end
      KIND_ALWAYS: begin
        upd.counter = '0;
      end
      KIND_PERIODIC: begin
        // wraps once the count passes the interval
        upd.counter = (cnt_inc > {1'b0, rd_q.interval}) ? '0 : cnt_inc[15:0];
      end
      default: begin
        upd = rd_q;
      end
    endcase
    disp   = rd_q.active && (rd_q.counter == '0);
    rep_ok = disp && (nd_r < MAX_REPORT);
    // a new dispatch must first push the held one out
    stall  = rep_ok && held_v_r && !out_free;
  end

  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    idx_nxt         = idx_r;
    pos_nxt         = pos_r;
    held_v_nxt      = held_v_r;
    nd_nxt          = nd_r;
    rq_nxt          = rq_r;
    rep_kind_nxt    = rep_kind_r;
    rep_id_nxt      = rep_id_r;
    held_id_nxt     = held_id_r;
    held_handle_nxt = held_handle_r;
    mem_we          = 1'b0;
    mem_wa          = idx_r;
    mem_wd          = rd_q;
    mem_re          = 1'b0;
    mem_ra          = idx_r;
    push            = 1'b0;
    push_kind       = RES_QUIET;
    push_id         = '0;
    push_handle     = '0;
    push_last       = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          rq_nxt.handle       = in_task_handle;
          rq_nxt.kind         = in_task_kind;
          rq_nxt.active       = in_start_active;
          rq_nxt.priority_lvl = in_task_priority;
          rq_nxt.interval     = in_tick_interval;
          rq_nxt.counter      = '0;
          unique case (in_req_type)
            REQ_ATTACH: begin
              if (cnt_r == CW'(SLOTS)) begin
                rep_kind_nxt = RES_FULL;
                rep_id_nxt   = '0;
                state_nxt    = S_REPLY;
              end else if (cnt_r == '0) begin
                pos_nxt   = '0;
                state_nxt = S_ATT_WR;
              end else begin
                // scan down from the last occupied slot
                mem_re    = 1'b1;
                mem_ra    = IW'(cnt_r - CW'(1));
                idx_nxt   = IW'(cnt_r - CW'(1));
                state_nxt = S_ATT_CHK;
              end
            end
            REQ_TICK: begin
              held_v_nxt = 1'b0;
              nd_nxt     = '0;
              if (cnt_r == '0) begin
                state_nxt = S_TK_END;
              end else begin
                mem_re    = 1'b1;
                mem_ra    = '0;
                idx_nxt   = '0;
                state_nxt = S_TK_CHK;
              end
            end
            REQ_TOGGLE: begin
              if (XW'(in_toggle_id) < XW'(cnt_r)) begin
                mem_re    = 1'b1;
                mem_ra    = tg_idx;
                idx_nxt   = tg_idx;
                state_nxt = S_TG_CHK;
              end else begin
                rep_kind_nxt = RES_NOSUCH;
                rep_id_nxt   = in_toggle_id;
                state_nxt    = S_REPLY;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_ATT_CHK: begin
        if (rd_q.priority_lvl >= rq_r.priority_lvl) begin
          // equal or lower urgency moves up one slot
          mem_we = 1'b1;
          mem_wa = idx_r + IW'(1);
          mem_wd = rd_q;
          if (idx_r == '0) begin
            pos_nxt   = '0;
            state_nxt = S_ATT_WR;
          end else begin
            mem_re  = 1'b1;
            mem_ra  = idx_r - IW'(1);
            idx_nxt = idx_r - IW'(1);
          end
        end else begin
          pos_nxt   = idx_r + IW'(1);
          state_nxt = S_ATT_WR;
        end
      end

      S_ATT_WR: begin
        if (out_free) begin
          mem_we    = 1'b1;
          mem_wa    = pos_r;
          mem_wd    = rq_r;
          cnt_nxt   = cnt_r + CW'(1);
          push      = 1'b1;
          push_kind = RES_ATTACHED;
          push_id   = 3'(pos_r);
          state_nxt = S_IDLE;
        end
      end

      S_TG_CHK: begin
        if (out_free) begin
          mem_we        = 1'b1;
          mem_wa        = idx_r;
          mem_wd        = rd_q;
          mem_wd.active = !rd_q.active;
          push          = 1'b1;
          push_kind     = RES_TOGGLED;
          push_id       = 3'(idx_r);
          state_nxt     = S_IDLE;
        end
      end

      S_REPLY: begin
        if (out_free) begin
          push      = 1'b1;
          push_kind = rep_kind_r;
          push_id   = rep_id_r;
          state_nxt = S_IDLE;
        end
      end

      S_TK_CHK: begin
        if (!stall) begin
          if (rd_q.active) begin
            mem_we = 1'b1;
            mem_wa = idx_r;
            mem_wd = upd;
          end
          if (rep_ok) begin
            // the last dispatch of a pass is held back until the pass ends
            if (held_v_r) begin
              push        = 1'b1;
              push_kind   = RES_DISPATCH;
              push_id     = held_id_r;
              push_handle = held_handle_r;
              push_last   = 1'b0;
            end
            held_v_nxt      = 1'b1;
            held_id_nxt     = 3'(idx_r);
            held_handle_nxt = rd_q.handle;
            nd_nxt          = nd_r + 4'd1;
          end
          if (next_idx < cnt_r) begin
            mem_re  = 1'b1;
            mem_ra  = idx_r + IW'(1);
            idx_nxt = idx_r + IW'(1);
          end else begin
            state_nxt = S_TK_END;
          end
        end
      end

      S_TK_END: begin
        if (out_free) begin
          push = 1'b1;
          if (held_v_r) begin
            push_kind   = RES_DISPATCH;
            push_id     = held_id_r;
            push_handle = held_handle_r;
          end else begin
            push_kind = RES_QUIET;
          end
          push_last  = 1'b1;
          held_v_nxt = 1'b0;
          state_nxt  = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      idx_r       <= '0;
      pos_r       <= '0;
      held_v_r    <= 1'b0;
      nd_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      idx_r    <= idx_nxt;
      pos_r    <= pos_nxt;
      held_v_r <= held_v_nxt;
      nd_r     <= nd_nxt;
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rq_r          <= rq_nxt;
    rep_kind_r    <= rep_kind_nxt;
    rep_id_r      <= rep_id_nxt;
    held_id_r     <= held_id_nxt;
    held_handle_r <= held_handle_nxt;
    if (push) begin
      out_kind_r   <= push_kind;
      out_id_r     <= push_id;
      out_handle_r <= push_handle;
      out_last_r   <= push_last;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_result_kind       = out_kind_r;
  assign out_slot_id           = out_id_r;
  assign out_dispatched_handle = out_handle_r;
  assign out_last_result       = out_last_r;

endmodule

### sv/ttd_checker.sv
module ttd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] in_req_type,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_result_kind,
  input logic [2:0] out_slot_id,
  input logic [7:0] out_dispatched_handle,
  input logic       out_last_result
);
  import ttd_pkg::*;

  // no result straight out of reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a waiting transaction keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_kind)
      && $stable(out_slot_id) && $stable(out_dispatched_handle)
      && $stable(out_last_result))
    else $error("stalled result changed");

  // handle only shows on a dispatch
  a_handle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind != RES_DISPATCH |-> out_dispatched_handle == '0)
    else $error("handle on non-dispatch result");

  // single-result items always close their item
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind != RES_DISPATCH |-> out_last_result)
    else $error("single result without last flag");

  // a real request leaves the block busy in the cycle after it is taken
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_req_type == REQ_ATTACH || in_req_type == REQ_TICK
      || in_req_type == REQ_TOGGLE) |=> !in_ready)
    else $error("new transaction taken while busy");

endmodule

bind tick_task_dispatcher_core ttd_checker u_ttd_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .in_valid              (in_valid),
  .in_ready              (in_ready),
  .in_req_type           (in_req_type),
  .out_valid             (out_valid),
  .out_ready             (out_ready),
  .out_result_kind       (out_result_kind),
  .out_slot_id           (out_slot_id),
  .out_dispatched_handle (out_dispatched_handle),
  .out_last_result       (out_last_result)
);

### tb/sv/tb_tick_task_dispatcher_core.sv
`timescale 1ns / 100ps

module tb_tick_task_dispatcher_core;
  import ttd_pkg::*;

  localparam int SLOTS = 8;
  // generous bound: every item with eight results behind a heavily stalling receiver
  localparam int CYCLE_LIMIT = 200000;
  // request and kind codes that the package leaves unnamed
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // one predicted result transaction
  typedef struct {
    logic [2:0] kind;
    logic [2:0] slot;
    logic [7:0] handle;
    logic       last;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_req_type = '0;
  logic [7:0]  in_task_handle = '0;
  logic [1:0]  in_task_kind = '0;
  logic        in_start_active = 1'b0;
  logic [7:0]  in_task_priority = '0;
  logic [15:0] in_tick_interval = '0;
  logic [2:0]  in_toggle_id = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_result_kind;
  logic [2:0]  out_slot_id;
  logic [7:0]  out_dispatched_handle;
  logic        out_last_result;

  // shadow copy of the slot table, kept in priority order
  slot_t       shadow_slots[SLOTS];
  int unsigned shadow_count = 0;

  // results still owed by the block, oldest first
  outcome_t    outcome_q[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;
  int cycle_count = 0;
  int results_checked = 0;
  int dispatches_seen = 0;
  int ticks_sent = 0;
  int toggles_sent = 0;
  int attaches_sent = 0;
  int ignored_sent = 0;

  tick_task_dispatcher_core #(
    .SLOTS(SLOTS)
  ) u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_req_type          (in_req_type),
    .in_task_handle       (in_task_handle),
    .in_task_kind         (in_task_kind),
    .in_start_active      (in_start_active),
    .in_task_priority     (in_task_priority),
    .in_tick_interval     (in_tick_interval),
    .in_toggle_id         (in_toggle_id),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_result_kind      (out_result_kind),
    .out_slot_id          (out_slot_id),
    .out_dispatched_handle(out_dispatched_handle),
    .out_last_result      (out_last_result)
  );

  always #2 clk = ~clk;

  // run guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tick_task_dispatcher_core verification failed");
      $finish;
    end
  end

  // receiver back-pressure, rate set per phase
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  function automatic void push_outcome(input logic [2:0] kind, input logic [2:0] slot,
                                       input logic [7:0] handle, input logic last);
    outcome_t o;
    o.kind = kind;
    o.slot = slot;
    o.handle = handle;
    o.last = last;
    outcome_q.push_back(o);
  endfunction

  // predicts the results of one accepted transaction and updates the shadow table
  function automatic void forecast_outcomes(input logic [1:0] req, input logic [7:0] hdl,
                                            input logic [1:0] knd, input logic act,
                                            input logic [7:0] prio, input logic [15:0] ivl,
                                            input logic [2:0] tog);
    int unsigned pos;
    int unsigned n;
    logic [16:0] nxt;
    case (req)
      REQ_ATTACH: begin
        if (shadow_count >= SLOTS) begin
          push_outcome(RES_FULL, 3'd0, 8'd0, 1'b1);
        end else begin
          // new entry lands ahead of any equal priority
          pos = 0;
          while (pos < shadow_count && shadow_slots[pos].priority_lvl < prio) pos++;
          for (int i = shadow_count; i > pos; i--) shadow_slots[i] = shadow_slots[i - 1];
          shadow_slots[pos] = '{handle: hdl, kind: knd, active: act, priority_lvl: prio,
                                interval: ivl, counter: 16'd0};
          shadow_count++;
          push_outcome(RES_ATTACHED, pos[2:0], 8'd0, 1'b1);
        end
      end
      REQ_TICK: begin
        n = 0;
        for (int i = 0; i < shadow_count; i++) begin
          if (shadow_slots[i].active) begin
            if (shadow_slots[i].counter == 16'd0 && n < MAX_REPORT) begin
              push_outcome(RES_DISPATCH, i[2:0], shadow_slots[i].handle, 1'b0);
              n++;
            end
            case (shadow_slots[i].kind)
              KIND_ONESHOT: begin
                shadow_slots[i].active = 1'b0;
                shadow_slots[i].counter = 16'd0;
              end
              KIND_ALWAYS: shadow_slots[i].counter = 16'd0;
              KIND_PERIODIC: begin
                nxt = {1'b0, shadow_slots[i].counter} + 17'd1;
                if (nxt > {1'b0, shadow_slots[i].interval}) nxt = '0;
                shadow_slots[i].counter = nxt[15:0];
              end
              default: ; // unused kind leaves counter and flag alone
            endcase
          end
        end
        if (n == 0) push_outcome(RES_QUIET, 3'd0, 8'd0, 1'b1);
        else outcome_q[$].last = 1'b1;
      end
      REQ_TOGGLE: begin
        if (tog < shadow_count) begin
          shadow_slots[tog].active = ~shadow_slots[tog].active;
          push_outcome(RES_TOGGLED, tog, 8'd0, 1'b1);
        end else begin
          push_outcome(RES_NOSUCH, tog, 8'd0, 1'b1);
        end
      end
      default: ; // unknown request yields nothing
    endcase
  endfunction

  // result checker: every accepted result transaction against the oldest prediction
  always @(posedge clk) begin
    outcome_t want;
    if (rst_n && out_valid && out_ready) begin
      results_checked++;
      if (outcome_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got kind=%0d slot=%0d handle=%0h last=%0b",
                 $time, out_result_kind, out_slot_id, out_dispatched_handle, out_last_result);
        mismatch_count++;
      end else begin
        want = outcome_q.pop_front();
        if (out_result_kind === RES_DISPATCH) dispatches_seen++;
        if (out_result_kind !== want.kind) begin
          $display("%0t: result_kind expected %0d, got %0d", $time, want.kind, out_result_kind);
          mismatch_count++;
        end
        if (out_slot_id !== want.slot) begin
          $display("%0t: slot_id expected %0d, got %0d", $time, want.slot, out_slot_id);
          mismatch_count++;
        end
        if (out_dispatched_handle !== want.handle) begin
          $display("%0t: dispatched_handle expected %0h, got %0h", $time, want.handle,
                   out_dispatched_handle);
          mismatch_count++;
        end
        if (out_last_result !== want.last) begin
          $display("%0t: last_result expected %0b, got %0b", $time, want.last, out_last_result);
          mismatch_count++;
        end
      end
    end
  end

  // drives one request transaction, waits for acceptance, then records the prediction;
  // valid is only lowered when an idle gap is inserted
  task automatic send_item(input logic [1:0] req, input logic [7:0] hdl, input logic [1:0] knd,
                           input logic act, input logic [7:0] prio, input logic [15:0] ivl,
                           input logic [2:0] tog);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_req_type      <= req;
    in_task_handle   <= hdl;
    in_task_kind     <= knd;
    in_start_active  <= act;
    in_task_priority <= prio;
    in_tick_interval <= ivl;
    in_toggle_id     <= tog;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    case (req)
      REQ_ATTACH: attaches_sent++;
      REQ_TICK:   ticks_sent++;
      REQ_TOGGLE: toggles_sent++;
      default:    ignored_sent++;
    endcase
    forecast_outcomes(req, hdl, knd, act, prio, ivl, tog);
  endtask

  task automatic send_attach(input logic [7:0] hdl, input logic [1:0] knd, input logic act,
                             input logic [7:0] prio, input logic [15:0] ivl);
    send_item(REQ_ATTACH, hdl, knd, act, prio, ivl, 3'd0);
  endtask

  task automatic send_tick();
    send_item(REQ_TICK, 8'd0, KIND_ALWAYS, 1'b0, 8'd0, 16'd0, 3'd0);
  endtask

  task automatic send_toggle(input logic [2:0] tog);
    send_item(REQ_TOGGLE, 8'd0, KIND_ALWAYS, 1'b0, 8'd0, 16'd0, tog);
  endtask

  // empty table: quiet tick, toggles with no task behind them, ignored request
  task automatic test_empty_table();
    send_tick();
    send_toggle(3'd0);
    send_toggle(3'd7);
    send_item(REQ_UNKNOWN, 8'hFF, KIND_UNUSED, 1'b1, 8'hFF, 16'hFFFF, 3'd7);
  endtask

  // insertion at front, middle, end and ahead of an equal priority
  task automatic test_priority_insert();
    send_attach(8'hFF, KIND_ALWAYS,   1'b1, 8'd128, 16'd0);
    send_attach(8'h00, KIND_PERIODIC, 1'b1, 8'd128, 16'd2);
    send_attach(8'h96, KIND_ONESHOT,  1'b1, 8'd255, 16'd0);
    send_attach(8'hA5, KIND_UNUSED,   1'b1, 8'd0,   16'd0);
    send_attach(8'h5A, KIND_PERIODIC, 1'b0, 8'd64,  16'd0);
  endtask

  // in-range toggles flip the flag, out-of-range ones report no such task
  task automatic test_toggle_range();
    send_toggle(3'd4);
    send_toggle(3'd5);
    send_toggle(3'd0);
  endtask

  // dispatch, one-shot retirement and periodic wrap over a few passes
  task automatic test_tick_dispatch();
    repeat (3) send_tick();
  endtask

  // last free slots, widest interval, then an attach refused by a full table
  task automatic test_fill_to_full();
    send_attach(8'h3C, KIND_PERIODIC, 1'b1, 8'd255, 16'd1);
    send_attach(8'hC3, KIND_ONESHOT,  1'b1, 8'd200, 16'd0);
    send_attach(8'h81, KIND_PERIODIC, 1'b1, 8'd255, 16'hFFFF);
    send_attach(8'hFF, KIND_UNUSED,   1'b1, 8'hFF,  16'hFFFF);
    repeat (2) send_tick();
  endtask

  // mixed traffic with every field randomised, ignored requests included
  task automatic test_random_traffic(input int items, input int idle_pct, input int stall_pct);
    int done;
    int sel;
    logic [1:0] req;
    done = 0;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    while (done < items) begin
      sel = $urandom_range(0, 99);
      if (sel < 45) req = REQ_TICK;
      else if (sel < 85) req = REQ_TOGGLE;
      else if (sel < 95) req = REQ_ATTACH;
      else req = REQ_UNKNOWN;
      send_item(req, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
                1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                16'($urandom_range(0, 65535)), 3'($urandom_range(0, 7)));
      done++;
    end
  endtask

  initial begin
    // synchronous reset, released before the tests start
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table();
    test_priority_insert();
    test_toggle_range();
    test_tick_dispatch();
    test_fill_to_full();

    // idling phases: none, sender idle, receiver stalling, both lightly
    test_random_traffic(90, 0, 0);
    test_random_traffic(90, 59, 0);
    test_random_traffic(90, 0, 59);
    test_random_traffic(90, 10, 10);

    in_valid <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk);
    // let any stray result surface
    repeat (SLOTS + 8) @(posedge clk);

    $display("covered %0d ticks, %0d toggles, %0d attaches and %0d ignored requests",
             ticks_sent, toggles_sent, attaches_sent, ignored_sent);
    $display("checked %0d result transactions, %0d of them dispatches",
             results_checked, dispatches_seen);
    if (mismatch_count == 0) begin
      $display("tick_task_dispatcher_core verification clean");
    end else begin
      $display("tick_task_dispatcher_core verification failed");
    end
    $finish;
  end

endmodule

### tick_task_dispatcher_core.f
sv/ttd_pkg.sv
sv/tick_task_dispatcher_core.sv
sv/ttd_checker.sv
tb/sv/tb_tick_task_dispatcher_core.sv
